// File: design/rnbm_pkg.sv
// ----------------------------------------------------------------------------
// rnbm_pkg
// Shared types, codes and saturating helpers for the ReLU neuron training core.
// ----------------------------------------------------------------------------
package rnbm_pkg;

  // Item modes on the input channel.
  localparam logic [2:0] MODE_FORWARD = 3'd0;
  localparam logic [2:0] MODE_OUTGRAD = 3'd1;
  localparam logic [2:0] MODE_HIDDEN  = 3'd2;
  localparam logic [2:0] MODE_UPDATE  = 3'd3;
  localparam logic [2:0] MODE_LOAD    = 3'd4;

  // Result kinds on the output channel.
  localparam logic [1:0] KIND_ACT    = 2'd0;
  localparam logic [1:0] KIND_GRAD   = 2'd1;
  localparam logic [1:0] KIND_WEIGHT = 2'd2;

  // Configuration register map (index taken from paddr[2]).
  localparam int         CFG_ADDR_W     = 3;
  localparam logic [0:0] REG_LEARN_RATE = 1'b0;
  localparam logic [0:0] REG_MOMENTUM   = 1'b1;
  localparam logic [15:0] LEARN_RATE_RST = 16'd655;
  localparam logic [15:0] MOMENTUM_RST   = 16'd32768;

  // Clamp of the scaled input-gradient product and its split for the multiplier.
  localparam logic signed [63:0] P_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] P_MIN   = -64'sh0000_8000_0000_0000;
  localparam int                 P_SPLIT = 24;

  typedef struct packed {
    logic [2:0]         mode;
    logic [5:0]         slot;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         kind;
  } out_item_t;

  // Request to the shared multiplier.
  typedef struct packed {
    logic               en;
    logic signed [32:0] op_a;
    logic signed [32:0] op_b;
  } mul_req_t;

  function automatic logic signed [63:0] sx64(input logic signed [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  function automatic logic signed [32:0] sx33(input logic signed [31:0] x);
    return {x[31], x};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    logic signed [63:0] r;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      r = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

// File: design/rnbm_stream_if.sv
// ----------------------------------------------------------------------------
// rnbm_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface rnbm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: design/rnbm_mul.sv
// ----------------------------------------------------------------------------
// rnbm_mul
// Shared signed 33 x 33 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module rnbm_mul (
  input  logic                     clk,
  input  rnbm_pkg::mul_req_t       req,
  output logic signed [63:0]       prod
);

  logic signed [65:0] full;

  // All operands used by the core fit a 64-bit product.
  assign full = req.op_a * req.op_b;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= full[63:0];
    end
  end

endmodule

// File: design/rnbm_cfg.sv
// ----------------------------------------------------------------------------
// rnbm_cfg
// APB register file holding the learning rate and the momentum factor.
// ----------------------------------------------------------------------------
module rnbm_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rnbm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output logic [15:0]                       learn_rate,
  output logic [15:0]                       momentum_factor
);

  logic [0:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[rnbm_pkg::CFG_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate      <= rnbm_pkg::LEARN_RATE_RST;
      momentum_factor <= rnbm_pkg::MOMENTUM_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        rnbm_pkg::REG_LEARN_RATE: learn_rate      <= pwdata[15:0];
        rnbm_pkg::REG_MOMENTUM:   momentum_factor <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read data decode.
  always_comb begin
    unique case (reg_idx)
      rnbm_pkg::REG_LEARN_RATE: prdata = {16'd0, learn_rate};
      rnbm_pkg::REG_MOMENTUM:   prdata = {16'd0, momentum_factor};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

// File: design/relu_neuron_backprop_momentum_core.sv
// ----------------------------------------------------------------------------
// relu_neuron_backprop_momentum_core
// Single ReLU neuron training engine in fixed point with momentum SGD updates.
// ----------------------------------------------------------------------------
// The core takes one input transaction at a time; in_ch.ready is high only while
// it is idle. All products go through one registered 33 x 33 multiplier, and the
// weight and delta memories are read once per transaction with registered data.
// A load and a non-final forward or hidden-gradient term return to idle with no
// result; an output-gradient item, a final term and an in-range weight update
// produce one. A weight update makes four passes through the multiplier plus the
// read-modify-write of both memories. The result is then parked in the output
// register, so the next transaction can be taken while it waits. After reset the
// core clears every entry of the delta memory before it first raises in_ch.ready;
// configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module relu_neuron_backprop_momentum_core #(
  parameter int MAX_INPUTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  rnbm_stream_if.sink                       in_ch,
  rnbm_stream_if.source                     out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rnbm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int             AW       = (MAX_INPUTS > 2) ? $clog2(MAX_INPUTS) : 1;
  localparam logic [AW-1:0]  LAST_IDX = AW'(MAX_INPUTS - 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_ACC, ST_UPD_P, ST_UPD_LO,
    ST_UPD_HI, ST_UPD_MOM, ST_UPD_T, ST_UPD_W, ST_DONE
  } state_t;

  state_t                   state;
  logic [AW-1:0]            clr_idx;
  rnbm_pkg::in_item_t       item;
  logic                     slot_ok;
  logic signed [31:0]       w_rd;
  logic signed [31:0]       d_rd;
  logic signed [63:0]       sum_acc;
  logic signed [31:0]       neuron_output;
  logic signed [31:0]       neuron_gradient;
  logic signed [47:0]       p_reg;
  logic signed [63:0]       work;
  logic signed [31:0]       d_new;
  rnbm_pkg::out_item_t      pend;
  rnbm_pkg::out_item_t      res;
  logic                     out_valid;

  logic [31:0]              weight_mem [MAX_INPUTS];
  logic [31:0]              delta_mem  [MAX_INPUTS];

  logic [15:0]              learn_rate;
  logic [15:0]              momentum_factor;
  rnbm_pkg::mul_req_t       mul_req;
  logic signed [63:0]       mul_prod;

  logic                     in_accept;
  logic [AW-1:0]            rd_idx;
  logic [AW-1:0]            wr_idx;
  logic                     w_we;
  logic [31:0]              w_wdata;
  logic                     d_we;
  logic [AW-1:0]            d_waddr;
  logic [31:0]              d_wdata;
  logic signed [31:0]       w_eff;
  logic signed [63:0]       acc_sum;
  logic signed [63:0]       acc_shift;
  logic signed [31:0]       acc_v;
  logic signed [31:0]       og_v;
  logic signed [63:0]       p_shift;
  logic signed [47:0]       p_clamp;
  logic signed [63:0]       t_sum;
  logic signed [31:0]       new_weight;

  // Configuration registers.
  rnbm_cfg u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .learn_rate      (learn_rate),
    .momentum_factor (momentum_factor)
  );

  // Shared multiplier.
  rnbm_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (mul_prod)
  );

  // Channel handshakes.
  assign in_ch.ready    = (state == ST_IDLE);
  assign in_accept      = in_ch.valid & in_ch.ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = res;

  assign rd_idx = AW'(in_ch.payload.slot);
  assign wr_idx = AW'(item.slot);

  // Arithmetic around the multiplier.
  always_comb begin
    w_eff     = slot_ok ? w_rd : 32'sd0;
    acc_sum   = rnbm_pkg::sat_add64(sum_acc, mul_prod);
    acc_shift = acc_sum >>> FRAC_BITS;
    acc_v     = rnbm_pkg::sat32(acc_shift);
    og_v      = rnbm_pkg::sat32(rnbm_pkg::sx64(item.value_a) -
                                rnbm_pkg::sx64(neuron_output));
    p_shift   = mul_prod >>> FRAC_BITS;
    if (p_shift > rnbm_pkg::P_MAX) begin
      p_clamp = rnbm_pkg::P_MAX[47:0];
    end else if (p_shift < rnbm_pkg::P_MIN) begin
      p_clamp = rnbm_pkg::P_MIN[47:0];
    end else begin
      p_clamp = p_shift[47:0];
    end
    t_sum      = (work >>> 16) + (mul_prod >>> 16);
    new_weight = rnbm_pkg::sat32(rnbm_pkg::sx64(w_rd) + rnbm_pkg::sx64(d_new));
  end

  // Multiplier operand selection per sequencer step.
  always_comb begin
    mul_req = '0;
    case (state)
      ST_DISPATCH: begin
        mul_req.op_a = rnbm_pkg::sx33(item.value_a);
        case (item.mode)
          rnbm_pkg::MODE_FORWARD: begin
            mul_req.en   = 1'b1;
            mul_req.op_b = rnbm_pkg::sx33(w_eff);
          end
          rnbm_pkg::MODE_HIDDEN: begin
            mul_req.en   = 1'b1;
            mul_req.op_b = rnbm_pkg::sx33(item.value_b);
          end
          rnbm_pkg::MODE_UPDATE: begin
            mul_req.en   = slot_ok;
            mul_req.op_b = rnbm_pkg::sx33(neuron_gradient);
          end
          default: ;
        endcase
      end
      ST_UPD_LO: begin
        mul_req.en   = 1'b1;
        mul_req.op_a = {9'd0, p_reg[rnbm_pkg::P_SPLIT-1:0]};
        mul_req.op_b = {17'd0, learn_rate};
      end
      ST_UPD_HI: begin
        mul_req.en   = 1'b1;
        mul_req.op_a = {{9{p_reg[47]}}, p_reg[47:rnbm_pkg::P_SPLIT]};
        mul_req.op_b = {17'd0, learn_rate};
      end
      ST_UPD_MOM: begin
        mul_req.en   = 1'b1;
        mul_req.op_a = rnbm_pkg::sx33(d_rd);
        mul_req.op_b = {17'd0, momentum_factor};
      end
      default: ;
    endcase
  end

  // Memory write controls.
  always_comb begin
    w_we    = (state == ST_UPD_W) ||
              (state == ST_DISPATCH && item.mode == rnbm_pkg::MODE_LOAD && slot_ok);
    w_wdata = (state == ST_UPD_W) ? new_weight : item.value_a;
    d_we    = (state == ST_CLEAR) || w_we;
    d_waddr = (state == ST_CLEAR) ? clr_idx : wr_idx;
    d_wdata = (state == ST_UPD_W) ? d_new : 32'd0;
  end

  // Weight and delta memories, read once per accepted transaction.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      w_rd <= weight_mem[rd_idx];
      d_rd <= delta_mem[rd_idx];
    end
    if (w_we) begin
      weight_mem[wr_idx] <= w_wdata;
    end
    if (d_we) begin
      delta_mem[d_waddr] <= d_wdata;
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clr_idx         <= '0;
      sum_acc         <= '0;
      neuron_output   <= '0;
      neuron_gradient <= '0;
      out_valid       <= 1'b0;
    end else begin
      // The completion step handles the output register itself.
      if (out_valid && out_ch.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            item    <= in_ch.payload;
            slot_ok <= (32'(in_ch.payload.slot) < 32'(MAX_INPUTS));
            state   <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          case (item.mode) inside
            rnbm_pkg::MODE_FORWARD, rnbm_pkg::MODE_HIDDEN: state <= ST_ACC;
            rnbm_pkg::MODE_OUTGRAD: begin
              pend.value      <= (neuron_output > 32'sd0) ? og_v : 32'sd0;
              pend.kind       <= rnbm_pkg::KIND_GRAD;
              neuron_gradient <= (neuron_output > 32'sd0) ? og_v : 32'sd0;
              state           <= ST_DONE;
            end
            rnbm_pkg::MODE_UPDATE: state <= slot_ok ? ST_UPD_P : ST_IDLE;
            default:               state <= ST_IDLE;
          endcase
        end
        ST_ACC: begin
          if (!item.last) begin
            sum_acc <= acc_sum;
            state   <= ST_IDLE;
          end else begin
            sum_acc <= '0;
            state   <= ST_DONE;
            if (item.mode == rnbm_pkg::MODE_FORWARD) begin
              neuron_output <= (acc_v > 32'sd0) ? acc_v : 32'sd0;
              pend.value    <= (acc_v > 32'sd0) ? acc_v : 32'sd0;
              pend.kind     <= rnbm_pkg::KIND_ACT;
            end else begin
              neuron_gradient <= (neuron_output > 32'sd0) ? acc_v : 32'sd0;
              pend.value      <= (neuron_output > 32'sd0) ? acc_v : 32'sd0;
              pend.kind       <= rnbm_pkg::KIND_GRAD;
            end
          end
        end
        ST_UPD_P: begin
          p_reg <= p_clamp;
          state <= ST_UPD_LO;
        end
        ST_UPD_LO: state <= ST_UPD_HI;
        ST_UPD_HI: begin
          work  <= mul_prod;
          state <= ST_UPD_MOM;
        end
        ST_UPD_MOM: begin
          work  <= work + (mul_prod <<< rnbm_pkg::P_SPLIT);
          state <= ST_UPD_T;
        end
        ST_UPD_T: begin
          d_new <= rnbm_pkg::sat32(t_sum);
          state <= ST_UPD_W;
        end
        ST_UPD_W: begin
          pend.value <= new_weight;
          pend.kind  <= rnbm_pkg::KIND_WEIGHT;
          state      <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ch.ready) begin
            res       <= pend;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The clearing pass must not overlap with accepted transactions.
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !in_ch.ready)
    else $error("input accepted during delta clearing pass");

  // A new result only appears from the completion step.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state == ST_DONE))
    else $error("result raised outside completion step");

  // Memory writes outside the clearing pass only for in-range loads and updates.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (d_we && state != ST_CLEAR) |-> slot_ok)
    else $error("memory write for out-of-range slot");

  // An accepted transaction always moves to dispatch.
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_DISPATCH))
    else $error("accepted transaction not dispatched");

endmodule
